// ===== design/julia_escape_time_pixel_top_assert.svh =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel engine: assertion macros
// Two forms of clocked implication check used by the engine's modules.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define JETS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define JETS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JETS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define JETS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/jets_pkg.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel engine: package
// Shared widths, register indexes, reset values and controller types.
// ----------------------------------------------------------------------------
package jets_pkg;

  localparam int PIX_W    = 12;
  localparam int ITER_W   = 10;
  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C_RE       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IM       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 4'd7;

  // Register reset values.
  localparam logic signed [COORD_W-1:0] C_IM_RST      = 32'sd268435456;
  localparam logic [RADIUS_W-1:0]       RADIUS_SQ_RST = 31'd702773148;
  localparam logic [ITER_W-1:0]         MAX_ITER_RST  = 10'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic map_mul;
    logic map_add;
    logic mul;
    logic sum;
    logic step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage

// ===== design/jets_ctrl.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel engine: controller
// Sequences mapping, the iteration passes and the result hand-over.
// ----------------------------------------------------------------------------
module jets_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  jets_pkg::dp_sts_t sts,
  output jets_pkg::dp_cmd_t cmd
);

  jets_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign in_ready  = (state_r == jets_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jets_pkg::ST_IDLE:    if (in_valid) state_nxt = jets_pkg::ST_MAP_MUL;
      jets_pkg::ST_MAP_MUL: state_nxt = jets_pkg::ST_MAP_ADD;
      jets_pkg::ST_MAP_ADD: state_nxt = jets_pkg::ST_MUL;
      jets_pkg::ST_MUL:     state_nxt = jets_pkg::ST_SUM;
      jets_pkg::ST_SUM:     state_nxt = jets_pkg::ST_UPD;
      jets_pkg::ST_UPD: begin
        state_nxt = sts.done ? jets_pkg::ST_DONE : jets_pkg::ST_MUL;
      end
      jets_pkg::ST_DONE:    if (slot_free) state_nxt = jets_pkg::ST_IDLE;
      default:              state_nxt = jets_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      jets_pkg::ST_IDLE:    cmd.load_in  = in_valid;
      jets_pkg::ST_MAP_MUL: cmd.map_mul  = 1'b1;
      jets_pkg::ST_MAP_ADD: cmd.map_add  = 1'b1;
      jets_pkg::ST_MUL:     cmd.mul      = 1'b1;
      jets_pkg::ST_SUM:     cmd.sum      = 1'b1;
      jets_pkg::ST_UPD:     cmd.step     = !sts.done;
      jets_pkg::ST_DONE:    cmd.out_load = slot_free;
      default:              cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jets_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "julia_escape_time_pixel_top_assert.svh"

  `JETS_ASSERT_NXT(a_accept_starts_map, clk, rst_n, in_valid && in_ready, state_r == jets_pkg::ST_MAP_MUL, "accepted pixel did not start mapping")
  `JETS_ASSERT_NXT(a_result_hand_over, clk, rst_n, cmd.out_load, out_valid_r && (state_r == jets_pkg::ST_IDLE), "result load did not present a result and return to idle")
  `JETS_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != jets_pkg::ST_IDLE, !in_ready, "input ready while a pixel is in progress")

endmodule

// ===== design/jets_dpath.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel engine: datapath
// Configuration registers, pixel mapping and the square-and-add unit.
// ----------------------------------------------------------------------------
module jets_dpath #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jets_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jets_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [jets_pkg::PIX_W-1:0]          in_pix_col,
  input  logic [jets_pkg::PIX_W-1:0]          in_pix_row,
  output logic [jets_pkg::ITER_W-1:0]         out_iter_count,
  output logic [jets_pkg::PIX_W-1:0]          out_col,
  output logic [jets_pkg::PIX_W-1:0]          out_row,
  input  jets_pkg::dp_cmd_t                   cmd,
  output jets_pkg::dp_sts_t                   sts
);

  localparam int DIM_CMP_W = 17;
  localparam logic [DIM_CMP_W-1:0]      DIM_LIMIT = DIM_CMP_W'(MAX_DIM);
  localparam logic [jets_pkg::PIX_W-1:0] DIM_LAST = jets_pkg::PIX_W'(MAX_DIM - 1);
  localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic fits;
    begin
      fits = (&v[63:31]) || (~|v[63:31]);
      if (fits) begin
        sat32 = v[31:0];
      end else begin
        sat32 = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end
  endfunction

  function automatic logic [jets_pkg::PIX_W-1:0] clamp_dim(
    input logic [jets_pkg::PIX_W-1:0] p
  );
    begin
      if (DIM_CMP_W'(p) >= DIM_LIMIT) begin
        clamp_dim = DIM_LAST;
      end else begin
        clamp_dim = p;
      end
    end
  endfunction

  // Configuration registers.
  logic signed [31:0]                 origin_re_r, origin_im_r, step_re_r, step_im_r;
  logic signed [31:0]                 c_re_r, c_im_r;
  logic [jets_pkg::RADIUS_W-1:0]      radius_r;
  logic [jets_pkg::ITER_W-1:0]        max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= '0;
      origin_im_r <= '0;
      step_re_r   <= '0;
      step_im_r   <= '0;
      c_re_r      <= '0;
      c_im_r      <= jets_pkg::C_IM_RST;
      radius_r    <= jets_pkg::RADIUS_SQ_RST;
      max_r       <= jets_pkg::MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jets_pkg::CFG_ORIGIN_RE: origin_re_r <= cfg_data;
        jets_pkg::CFG_ORIGIN_IM: origin_im_r <= cfg_data;
        jets_pkg::CFG_STEP_RE:   step_re_r   <= cfg_data;
        jets_pkg::CFG_STEP_IM:   step_im_r   <= cfg_data;
        jets_pkg::CFG_C_RE:      c_re_r      <= cfg_data;
        jets_pkg::CFG_C_IM:      c_im_r      <= cfg_data;
        jets_pkg::CFG_RADIUS_SQ: radius_r    <= cfg_data[jets_pkg::RADIUS_W-1:0];
        jets_pkg::CFG_MAX_ITER:  max_r       <= cfg_data[jets_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel capture and mapping.
  logic [jets_pkg::PIX_W-1:0] col_r, row_r, ccl_r, rcl_r;
  logic signed [44:0]         prod_re_nxt, prod_im_nxt, prod_re_r, prod_im_r;
  logic signed [63:0]         x_w, y_w;

  assign prod_re_nxt = 45'($signed({1'b0, ccl_r})) * 45'(step_re_r);
  assign prod_im_nxt = 45'($signed({1'b0, rcl_r})) * 45'(step_im_r);
  assign x_w = 64'(origin_re_r) + 64'(prod_re_r);
  assign y_w = 64'(origin_im_r) - 64'(prod_im_r);

  // Iteration unit: one pass is multiply, combine, update.
  logic signed [31:0]         zr_r, zi_r, nr_w, ni_w;
  logic signed [63:0]         a_r, b_r, p_r;
  logic signed [63:0]         diff_sh_r, cr_sh_r;
  logic [63:0]                sum_r, sum_hi;
  logic [jets_pkg::ITER_W-1:0] cnt_r, res_w;
  logic                       esc_w, esc_now;

  assign nr_w = sat32(diff_sh_r + 64'(c_re_r));
  assign ni_w = sat32(cr_sh_r + 64'(c_im_r));

  // The squares of the current z serve both the escape test and the next step.
  assign sum_hi = sum_r >> FRAC_BITS;
  assign esc_w  = (sum_hi > {33'd0, radius_r}) ||
                  ((sum_hi == {33'd0, radius_r}) && ((sum_r & FRAC_MASK) != 64'd0));
  // The starting point is never tested; only stepped values are.
  assign esc_now  = (cnt_r != '0) && esc_w;
  assign sts.done = esc_now || (cnt_r >= max_r);
  assign res_w    = esc_now ? (cnt_r - 1'b1) : cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_r <= in_pix_col;
      row_r <= in_pix_row;
      ccl_r <= clamp_dim(in_pix_col);
      rcl_r <= clamp_dim(in_pix_row);
      cnt_r <= '0;
    end
    if (cmd.map_mul) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
    end
    if (cmd.map_add) begin
      zr_r <= sat32(x_w);
      zi_r <= sat32(y_w);
    end
    if (cmd.mul) begin
      a_r <= 64'(zr_r) * 64'(zr_r);
      b_r <= 64'(zi_r) * 64'(zi_r);
      p_r <= 64'(zr_r) * 64'(zi_r);
    end
    if (cmd.sum) begin
      sum_r     <= 64'(unsigned'(a_r)) + 64'(unsigned'(b_r));
      diff_sh_r <= (a_r - b_r) >>> FRAC_BITS;
      cr_sh_r   <= p_r >>> (FRAC_BITS - 1);
    end
    if (cmd.step) begin
      zr_r  <= nr_w;
      zi_r  <= ni_w;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_iter_count <= res_w;
      out_col        <= col_r;
      out_row        <= row_r;
    end
  end

`include "julia_escape_time_pixel_top_assert.svh"

  `JETS_ASSERT_IMP(a_step_within_limit, clk, rst_n, cmd.step, cnt_r < max_r, "iteration step issued at or past the limit")
  `JETS_ASSERT_NXT(a_step_counts, clk, rst_n, cmd.step, cnt_r == ($past(cnt_r) + 10'd1), "iteration count did not advance by one")

endmodule

// ===== design/julia_escape_time_pixel_top.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel engine: top level
// A pixel goes in, its escape count comes out with the pixel tag.
// ----------------------------------------------------------------------------
// One pixel is worked at a time. After the input transfer the pixel is mapped
// to the plane by a multiply and then an add; each iteration pass over the
// single square-and-add unit then runs multiply, combine and update, and the
// result waits in a done state until the output register is free, then is
// loaded into it. The next pixel is taken in the cycle after the result is
// loaded, even if that result still waits. Configuration writes are always
// ready and must only be made while no pixel is in flight.
module julia_escape_time_pixel_top #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [jets_pkg::PIX_W-1:0]      in_pix_col,
  input  logic [jets_pkg::PIX_W-1:0]      in_pix_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [jets_pkg::ITER_W-1:0]     out_iter_count,
  output logic [jets_pkg::PIX_W-1:0]      out_col,
  output logic [jets_pkg::PIX_W-1:0]      out_row,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jets_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jets_pkg::CFG_DATA_W-1:0] cfg_data
);

  jets_pkg::dp_cmd_t cmd;
  jets_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  jets_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jets_dpath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pix_col     (in_pix_col),
    .in_pix_row     (in_pix_row),
    .out_iter_count (out_iter_count),
    .out_col        (out_col),
    .out_row        (out_row),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== bench/julia_escape_time_pixel_top_test.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel engine: testbench
// Sends pixels through the valid/ready input channel under several register
// settings and checks every escape count and pixel tag against a fixed-point
// predictor kept inside the bench. A short directed part covers the field
// extremes and corner settings, then randomized scenes follow under three
// patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_top_test;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 28;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int FOUR_Q    = 4 * ONE_Q;
  localparam int TAIL_CYCLES = 3 * 1023 + 20;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // Indexes past the register file, which the block has to ignore.
  localparam logic [jets_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
  localparam logic [jets_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

  typedef enum int {SCENE_IMAGE, SCENE_DEEP, SCENE_WILD, SCENE_SHALLOW} scene_t;

  typedef struct packed {
    logic [jets_pkg::PIX_W-1:0] col;
    logic [jets_pkg::PIX_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [jets_pkg::ITER_W-1:0] count;
    logic [jets_pkg::PIX_W-1:0]  col;
    logic [jets_pkg::PIX_W-1:0]  row;
  } escape_t;

  typedef struct packed {
    logic [jets_pkg::CFG_IDX_W-1:0]  index;
    logic [jets_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [jets_pkg::PIX_W-1:0]      in_pix_col = '0;
  logic [jets_pkg::PIX_W-1:0]      in_pix_row = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [jets_pkg::ITER_W-1:0]     out_iter_count;
  logic [jets_pkg::PIX_W-1:0]      out_col;
  logic [jets_pkg::PIX_W-1:0]      out_row;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [jets_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jets_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the register file.
  logic signed [jets_pkg::COORD_W-1:0] plane_origin_re;
  logic signed [jets_pkg::COORD_W-1:0] plane_origin_im;
  logic signed [jets_pkg::COORD_W-1:0] plane_step_re;
  logic signed [jets_pkg::COORD_W-1:0] plane_step_im;
  logic signed [jets_pkg::COORD_W-1:0] plane_c_re;
  logic signed [jets_pkg::COORD_W-1:0] plane_c_im;
  logic [jets_pkg::RADIUS_W-1:0]       plane_radius_sq;
  logic [jets_pkg::ITER_W-1:0]         iter_limit;

  pixel_t     pending_pixels[$];
  reg_write_t pending_writes[$];
  escape_t    expected_escapes[$];
  escape_t    head;
  escape_t    fresh;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixels_queued = 0;
  int pixels_accepted = 0;
  int writes_queued = 0;
  int writes_done = 0;
  int results_checked = 0;
  int escaped_count = 0;
  int bounded_count = 0;
  int deepest = 0;
  int settings_run = 0;
  int mismatch_count = 0;

  julia_escape_time_pixel_top #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pix_col    (in_pix_col),
    .in_pix_row    (in_pix_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_iter_count(out_iter_count),
    .out_col       (out_col),
    .out_row       (out_row),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic signed [jets_pkg::COORD_W-1:0] clip32(input longint v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Maps the pixel to the plane and iterates z = z*z + c until the squared
  // magnitude passes the radius or the limit is reached.
  function automatic logic [jets_pkg::ITER_W-1:0] escape_count(
    input logic [jets_pkg::PIX_W-1:0] col,
    input logic [jets_pkg::PIX_W-1:0] row
  );
    longint cc, rr, sq, prod_ri;
    logic signed [jets_pkg::COORD_W-1:0] zr, zi;
    logic [63:0] mag, bound;
    int n;
    cc = (col >= MAX_DIM) ? longint'(MAX_DIM - 1) : longint'(col);
    rr = (row >= MAX_DIM) ? longint'(MAX_DIM - 1) : longint'(row);
    zr = clip32(longint'(plane_origin_re) + cc * longint'(plane_step_re));
    zi = clip32(longint'(plane_origin_im) - rr * longint'(plane_step_im));
    bound = {33'd0, plane_radius_sq} << FRAC_BITS;
    for (n = 0; n < iter_limit; n++) begin
      sq = longint'(zr) * longint'(zr) - longint'(zi) * longint'(zi);
      prod_ri = longint'(zr) * longint'(zi);
      zr = clip32((sq >>> FRAC_BITS) + longint'(plane_c_re));
      zi = clip32((prod_ri >>> (FRAC_BITS - 1)) + longint'(plane_c_im));
      mag = unsigned'(longint'(zr) * longint'(zr)) + unsigned'(longint'(zi) * longint'(zi));
      if (mag > bound) break;
    end
    return n[jets_pkg::ITER_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH: %s", msg);
  endtask

  // Pixel driver: a new transfer is offered only once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        {in_pix_col, in_pix_row} <= pending_pixels.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (pending_writes.size() != 0) begin
        {cfg_index, cfg_data} <= pending_writes.pop_front();
        cfg_valid <= 1'b1;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: tracks register writes, checks results and predicts new pixels.
  always @(posedge clk) begin
    if (!rst_n) begin
      plane_origin_re = '0;
      plane_origin_im = '0;
      plane_step_re   = '0;
      plane_step_im   = '0;
      plane_c_re      = '0;
      plane_c_im      = jets_pkg::C_IM_RST;
      plane_radius_sq = jets_pkg::RADIUS_SQ_RST;
      iter_limit      = jets_pkg::MAX_ITER_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        writes_done++;
        case (cfg_index)
          jets_pkg::CFG_ORIGIN_RE: plane_origin_re = $signed(cfg_data);
          jets_pkg::CFG_ORIGIN_IM: plane_origin_im = $signed(cfg_data);
          jets_pkg::CFG_STEP_RE:   plane_step_re   = $signed(cfg_data);
          jets_pkg::CFG_STEP_IM:   plane_step_im   = $signed(cfg_data);
          jets_pkg::CFG_C_RE:      plane_c_re      = $signed(cfg_data);
          jets_pkg::CFG_C_IM:      plane_c_im      = $signed(cfg_data);
          jets_pkg::CFG_RADIUS_SQ: plane_radius_sq = cfg_data[jets_pkg::RADIUS_W-1:0];
          jets_pkg::CFG_MAX_ITER:  iter_limit      = cfg_data[jets_pkg::ITER_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_escapes.size() == 0) begin
          report_mismatch($sformatf("unexpected result count %0d col %0d row %0d",
                                    out_iter_count, out_col, out_row));
        end else begin
          head = expected_escapes.pop_front();
          if (out_iter_count !== head.count)
            report_mismatch($sformatf("iter_count %0d, expected %0d (col %0d row %0d)",
                                      out_iter_count, head.count, head.col, head.row));
          if (out_col !== head.col)
            report_mismatch($sformatf("out_col %0d, expected %0d", out_col, head.col));
          if (out_row !== head.row)
            report_mismatch($sformatf("out_row %0d, expected %0d", out_row, head.row));
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        fresh.count = escape_count(in_pix_col, in_pix_row);
        fresh.col   = in_pix_col;
        fresh.row   = in_pix_row;
        expected_escapes.push_back(fresh);
        pixels_accepted++;
        if (fresh.count == iter_limit) bounded_count++;
        else escaped_count++;
        if (int'(fresh.count) > deepest) deepest = int'(fresh.count);
      end
    end
  end

  task automatic queue_pixel(input logic [jets_pkg::PIX_W-1:0] col,
                             input logic [jets_pkg::PIX_W-1:0] row);
    pending_pixels.push_back('{col: col, row: row});
    pixels_queued++;
  endtask

  task automatic queue_random_pixels(input int count);
    int unsigned pick_col, pick_row;
    for (int k = 0; k < count; k++) begin
      pick_col = $urandom_range(MAX_DIM - 1);
      pick_row = $urandom_range(MAX_DIM - 1);
      queue_pixel(pick_col[jets_pkg::PIX_W-1:0], pick_row[jets_pkg::PIX_W-1:0]);
    end
  endtask

  task automatic queue_write(input logic [jets_pkg::CFG_IDX_W-1:0] index,
                             input logic [jets_pkg::CFG_DATA_W-1:0] data);
    pending_writes.push_back('{index: index, data: data});
    writes_queued++;
  endtask

  // Waits until every pixel has been taken and its result checked, then
  // lets the block return to idle.
  task automatic drain();
    while (pixels_accepted != pixels_queued || expected_escapes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic settle_writes();
    while (writes_done != writes_queued) @(posedge clk);
    @(posedge clk);
    settings_run++;
  endtask

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic setup_scene(input scene_t scene);
    if (scene == SCENE_WILD) begin
      queue_write(jets_pkg::CFG_ORIGIN_RE, $urandom);
      queue_write(jets_pkg::CFG_ORIGIN_IM, $urandom);
      queue_write(jets_pkg::CFG_STEP_RE, $urandom);
      queue_write(jets_pkg::CFG_STEP_IM, $urandom);
      queue_write(jets_pkg::CFG_C_RE, $urandom);
      queue_write(jets_pkg::CFG_C_IM, $urandom);
      queue_write(jets_pkg::CFG_RADIUS_SQ, $urandom);
      queue_write(jets_pkg::CFG_MAX_ITER, $urandom);
    end else begin
      // The view spans up to four units across, starting left of and above
      // the center of the plane.
      queue_write(jets_pkg::CFG_ORIGIN_RE, rand_between(-2 * ONE_Q, -ONE_Q / 2));
      queue_write(jets_pkg::CFG_ORIGIN_IM, rand_between(ONE_Q / 2, 2 * ONE_Q));
      queue_write(jets_pkg::CFG_STEP_RE, rand_between(ONE_Q >> 14, ONE_Q >> 10));
      queue_write(jets_pkg::CFG_STEP_IM, rand_between(ONE_Q >> 14, ONE_Q >> 10));
      if (scene == SCENE_DEEP) begin
        // A constant inside the connected set keeps many orbits bounded.
        queue_write(jets_pkg::CFG_C_RE, -(2 * ONE_Q) / 5);
        queue_write(jets_pkg::CFG_C_IM, (3 * ONE_Q) / 5);
        queue_write(jets_pkg::CFG_RADIUS_SQ, FOUR_Q);
        queue_write(jets_pkg::CFG_MAX_ITER, 1023);
      end else begin
        queue_write(jets_pkg::CFG_C_RE, rand_between(-ONE_Q, ONE_Q / 2));
        queue_write(jets_pkg::CFG_C_IM, rand_between(-ONE_Q, ONE_Q));
        queue_write(jets_pkg::CFG_RADIUS_SQ, ($urandom_range(3) == 0) ? $urandom : FOUR_Q);
        queue_write(jets_pkg::CFG_MAX_ITER,
                    (scene == SCENE_SHALLOW) ? 1 : $urandom_range(2, 100));
      end
    end
  endtask

  initial begin
    scene_t scene;
    int items;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 29;
    recv_idle_pct = 53;

    // Reset settings: every pixel maps to zero and the orbit of c = i repeats
    // without escaping, so each count is the default limit.
    queue_pixel(12'h000, 12'h000);
    queue_pixel(12'hFFF, 12'hFFF);
    queue_pixel(12'hAAA, 12'h555);
    drain();

    // Writes past the register file must leave every register alone.
    queue_write(CFG_UNUSED_LO, ONE_Q);
    queue_write(CFG_UNUSED_HI, 32'h8000_0005);
    settle_writes();
    queue_pixel(12'd7, 12'd9);
    drain();

    // A zero iteration limit runs no step at all.
    queue_write(jets_pkg::CFG_MAX_ITER, 0);
    settle_writes();
    queue_pixel(12'hFFF, 12'h000);
    queue_pixel(12'h555, 12'hAAA);
    drain();

    // Extreme registers: coordinates and z components saturate.
    queue_write(jets_pkg::CFG_ORIGIN_RE, 32'h8000_0000);
    queue_write(jets_pkg::CFG_ORIGIN_IM, 32'h7FFF_FFFF);
    queue_write(jets_pkg::CFG_STEP_RE, 32'h7FFF_FFFF);
    queue_write(jets_pkg::CFG_STEP_IM, 32'h8000_0000);
    queue_write(jets_pkg::CFG_C_RE, 32'h7FFF_FFFF);
    queue_write(jets_pkg::CFG_C_IM, 32'h8000_0000);
    queue_write(jets_pkg::CFG_RADIUS_SQ, 32'h7FFF_FFFF);
    queue_write(jets_pkg::CFG_MAX_ITER, 1023);
    settle_writes();
    queue_pixel(12'h000, 12'h000);
    queue_pixel(12'hFFF, 12'hFFF);
    queue_pixel(12'h001, 12'hFFF);
    queue_pixel(12'hFFF, 12'h000);
    drain();

    // All zero with a zero radius: z stays at zero and never passes it.
    queue_write(jets_pkg::CFG_ORIGIN_RE, 0);
    queue_write(jets_pkg::CFG_ORIGIN_IM, 0);
    queue_write(jets_pkg::CFG_STEP_RE, 0);
    queue_write(jets_pkg::CFG_STEP_IM, 0);
    queue_write(jets_pkg::CFG_C_RE, 0);
    queue_write(jets_pkg::CFG_C_IM, 0);
    queue_write(jets_pkg::CFG_RADIUS_SQ, 0);
    settle_writes();
    queue_pixel(12'h123, 12'hEDC);
    drain();

    // With c = 2 the first z lands exactly on a squared radius of four, which is
    // not an escape; one least significant bit less in the squared radius makes it one.
    queue_write(jets_pkg::CFG_C_RE, 2 * ONE_Q);
    queue_write(jets_pkg::CFG_RADIUS_SQ, FOUR_Q);
    queue_write(jets_pkg::CFG_MAX_ITER, 5);
    settle_writes();
    queue_pixel(12'h800, 12'h7FF);
    drain();
    queue_write(jets_pkg::CFG_RADIUS_SQ, FOUR_Q - 1);
    settle_writes();
    queue_pixel(12'h7FF, 12'h800);
    drain();

    // A plain picture setting over a three by three view.
    queue_write(jets_pkg::CFG_ORIGIN_RE, -(3 * ONE_Q) / 2);
    queue_write(jets_pkg::CFG_ORIGIN_IM, (3 * ONE_Q) / 2);
    queue_write(jets_pkg::CFG_STEP_RE, (3 * ONE_Q) / MAX_DIM);
    queue_write(jets_pkg::CFG_STEP_IM, (3 * ONE_Q) / MAX_DIM);
    queue_write(jets_pkg::CFG_C_RE, -214748365);
    queue_write(jets_pkg::CFG_C_IM, 41875931);
    queue_write(jets_pkg::CFG_MAX_ITER, 100);
    settle_writes();
    queue_pixel(12'd2048, 12'd2048);
    queue_pixel(12'd1024, 12'd2048);
    queue_pixel(12'd2600, 12'd1900);
    queue_pixel(12'hFFF, 12'h000);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 29;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      scene = (phase == 5) ? SCENE_DEEP :
              (phase == 3) ? SCENE_SHALLOW :
              (phase % 3 == 1) ? SCENE_WILD : SCENE_IMAGE;
      items = (scene == SCENE_DEEP) ? 10 : (scene == SCENE_WILD) ? 80 : 155;
      setup_scene(scene);
      settle_writes();
      // The sender holds back halfway until the block has emptied.
      queue_random_pixels(items / 2);
      drain();
      queue_random_pixels(items - items / 2);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d pixel results over %0d register settings (%0d register writes).",
             results_checked, settings_run, writes_done);
    $display("%0d pixels escaped, %0d reached the limit; highest count seen %0d.",
             escaped_count, bounded_count, deepest);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/jets_pkg.sv
design/jets_ctrl.sv
design/jets_dpath.sv
design/julia_escape_time_pixel_top.sv
bench/julia_escape_time_pixel_top_test.sv
